>>> hdl/periodic_task_dispatch_table_defines.svh
// ----------------------------------------------------------------------------
// Periodic task dispatch table - assertion macros
// Shared concurrent assertion forms used at the top level.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCH_TABLE_DEFINES_SVH
`define PERIODIC_TASK_DISPATCH_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PTDT_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ptdt: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PTDT_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ptdt: next-cycle check failed");

`endif

>>> hdl/ptdt_pkg.sv
// ----------------------------------------------------------------------------
// ptdt_pkg
// Types and constants of the periodic task dispatch table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptdt_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int MAX_OUT    = 16;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);

    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 24;

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_DEREGISTER = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DUP     = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic stall;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

>>> hdl/ptdt_ctrl.sv
// ----------------------------------------------------------------------------
// ptdt_ctrl
// Sequencer: accept one beat, scan the slot table, then post the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire ptdt_pkg::stat_t stat,
    output ptdt_pkg::cmd_t      cmd
);
    import ptdt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stat.stall && stat.scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN:
            begin
                cmd.step = !stat.stall;
            end
            ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/ptdt_datapath.sv
// ----------------------------------------------------------------------------
// ptdt_datapath
// Slot table, scan pointer, search flags, pending dispatch and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdt_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [ptdt_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ptdt_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [0:0]                           m_tuser,
    output logic                                 m_tlast,
    input  wire ptdt_pkg::cmd_t                  cmd,
    output ptdt_pkg::stat_t                      stat
);
    import ptdt_pkg::*;

    // slot table
    logic [TASK_SLOTS-1:0] active_reg;
    logic [15:0]           key_tab_reg  [TASK_SLOTS];
    logic [31:0]           intv_tab_reg [TASK_SLOTS];
    logic [31:0]           run_tab_reg  [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] rep_tab_reg;

    // current item
    logic [1:0]  op_reg;
    logic [15:0] key_reg;
    logic [31:0] intv_reg;
    logic        rep_reg;
    logic [31:0] now_reg;

    // scan state
    logic [SLOT_W-1:0] idx_reg;
    logic              match_reg;
    logic [SLOT_W-1:0] match_idx_reg;
    logic              free_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              pend_reg;
    logic [15:0]       pend_key_reg;
    logic [3:0]        pend_slot_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic        out_dv_reg;
    logic [15:0] out_key_reg;
    logic [3:0]  out_slot_reg;
    logic        out_last_reg;

    logic        cur_active;
    logic [31:0] elapsed;
    logic        key_hit;
    logic        due;
    logic        advance;
    logic        push;
    logic        out_free;
    logic        reg_ok;
    logic [1:0]  fin_status;

    assign cur_active = active_reg[idx_reg];
    assign elapsed    = now_reg - run_tab_reg[idx_reg];
    assign key_hit    = cur_active && (key_tab_reg[idx_reg] == key_reg);
    assign due        = (op_reg == OP_TICK) && cur_active && (elapsed >= intv_tab_reg[idx_reg])
                        && (cnt_reg < CNT_W'(MAX_OUT));
    assign out_free   = !out_valid_reg || m_tready;

    assign stat.scan_end = (idx_reg == SLOT_W'(TASK_SLOTS - 1));
    assign stat.stall    = due && pend_reg && !out_free;
    assign stat.out_free = out_free;

    assign advance = cmd.step;
    assign push    = advance && due && pend_reg;
    assign reg_ok  = (op_reg == OP_REGISTER) && !match_reg && free_reg;

    always_comb
    begin
        case (op_reg)
            OP_REGISTER:
            begin
                if (match_reg)
                begin
                    fin_status = STAT_DUP;
                end
                else if (free_reg)
                begin
                    fin_status = STAT_OK;
                end
                else
                begin
                    fin_status = STAT_FULL;
                end
            end
            OP_DEREGISTER:
            begin
                fin_status = match_reg ? STAT_OK : STAT_MISSING;
            end
            default:
            begin
                fin_status = STAT_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            idx_reg       <= '0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                idx_reg   <= '0;
                match_reg <= 1'b0;
                free_reg  <= 1'b0;
                cnt_reg   <= '0;
                pend_reg  <= 1'b0;
            end
            if (advance)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
                if (key_hit)
                begin
                    match_reg <= 1'b1;
                end
                if (!cur_active)
                begin
                    free_reg <= 1'b1;
                end
                if (due)
                begin
                    pend_reg <= 1'b1;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (!rep_tab_reg[idx_reg])
                    begin
                        active_reg[idx_reg] <= 1'b0;
                    end
                end
            end
            if (cmd.finish)
            begin
                if (reg_ok)
                begin
                    active_reg[free_idx_reg] <= 1'b1;
                end
                if ((op_reg == OP_DEREGISTER) && match_reg)
                begin
                    active_reg[match_idx_reg] <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= s_tuser;
            key_reg  <= s_tdata[15:0];
            intv_reg <= s_tdata[47:16];
            rep_reg  <= s_tdata[48];
            now_reg  <= s_tdata[80:49];
        end
        if (advance)
        begin
            if (key_hit && !match_reg)
            begin
                match_idx_reg <= idx_reg;
            end
            if (!cur_active && !free_reg)
            begin
                free_idx_reg <= idx_reg;
            end
            if (due)
            begin
                pend_key_reg  <= key_tab_reg[idx_reg];
                pend_slot_reg <= 4'(idx_reg);
                if (rep_tab_reg[idx_reg])
                begin
                    run_tab_reg[idx_reg] <= now_reg;
                end
            end
            if (push)
            begin
                out_status_reg <= STAT_OK;
                out_dv_reg     <= 1'b1;
                out_key_reg    <= pend_key_reg;
                out_slot_reg   <= pend_slot_reg;
                out_last_reg   <= 1'b0;
            end
        end
        if (cmd.finish)
        begin
            out_status_reg <= fin_status;
            out_last_reg   <= 1'b1;
            if ((op_reg == OP_TICK) && pend_reg)
            begin
                out_dv_reg   <= 1'b1;
                out_key_reg  <= pend_key_reg;
                out_slot_reg <= pend_slot_reg;
            end
            else
            begin
                out_dv_reg   <= 1'b0;
                out_key_reg  <= '0;
                out_slot_reg <= '0;
            end
            if (reg_ok)
            begin
                key_tab_reg[free_idx_reg]  <= key_reg;
                intv_tab_reg[free_idx_reg] <= intv_reg;
                run_tab_reg[free_idx_reg]  <= '0;
                rep_tab_reg[free_idx_reg]  <= rep_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_slot_reg, out_key_reg, out_status_reg};
    assign m_tuser  = out_dv_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> hdl/periodic_task_dispatch_table.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatch_table
// Task slot table with register, deregister and timed dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: s_tuser is the op (register, deregister, tick), s_tdata
//   carries key, interval, periodic mark and current time.
//   Result beats on m_*: m_tuser flags a dispatch, m_tdata carries status, key
//   and slot, m_tlast marks the final result of an input beat.
//   Every input beat runs one scan over the slot table, one slot per cycle
//   unless a due task waits on a busy output.
//   Register and deregister give one result. A tick gives one dispatch per
//   due task in slot order, or one empty result when nothing is due.
//   Reset empties the table; no clearing pass is needed.
//   A stalled receiver holds the output register; the scan stops on the next
//   due task until the result is taken. A new input beat is taken as soon as
//   the previous final result sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_dispatch_table_defines.svh"

module periodic_task_dispatch_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_tdata: task_key[15:0], interval_ms[47:16], periodic[48], now_ms[80:49]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ptdt_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: op[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: status[1:0], due_key[17:2], due_slot[21:18]
    output logic [ptdt_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: dispatch_valid[0]
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast
);
    import ptdt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ptdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptdt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    `PTDT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `PTDT_ASSERT_IMP(a_empty_is_last, clk, rst_n, m_tvalid && !m_tuser[0], m_tlast)
    `PTDT_ASSERT_IMP(a_dispatch_ok, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[1:0] == STAT_OK)

endmodule

`default_nettype wire
